FILE: hdl/dead_channel_detector_top_defines.svh
// ---------------------------------------------------------------------------
// dead channel detector assertion macros
// shared property wrappers for the port checker
// ---------------------------------------------------------------------------
`ifndef DEAD_CHANNEL_DETECTOR_TOP_DEFINES_SVH
`define DEAD_CHANNEL_DETECTOR_TOP_DEFINES_SVH

// same-cycle implication, disabled while reset is held
`define DCD_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled while reset is held
`define DCD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hdl/dcd_pkg.sv
// ---------------------------------------------------------------------------
// dcd_pkg
// widths, register codes and controller/datapath interface types
// ---------------------------------------------------------------------------
`default_nettype none

package dcd_pkg;

  localparam int SAMPLE_BITS    = 12;
  localparam int MAX_BUCKETS    = 512;
  localparam int END_BITS       = 10;
  localparam int LIMIT_BITS     = 12;
  localparam int INDEX_BITS     = 10;
  localparam int CFG_INDEX_BITS = 2;
  localparam int CFG_DATA_BITS  = 12;

  // last examined bucket is at most MAX_BUCKETS-1
  localparam int N_BITS     = $clog2(MAX_BUCKETS);
  localparam int SUM_BITS   = SAMPLE_BITS + N_BITS;
  localparam int SQ_BITS    = 2 * SAMPLE_BITS + N_BITS;
  localparam int PROD_BITS  = N_BITS + SQ_BITS;
  localparam int NN_BITS    = 2 * N_BITS;
  localparam int NL2_BITS   = 2 * LIMIT_BITS;
  localparam int QB_BITS    = NL2_BITS + NN_BITS;
  localparam int PB_BITS    = LIMIT_BITS + N_BITS;
  localparam int WIDE_BITS  = (PROD_BITS > QB_BITS) ? PROD_BITS : QB_BITS;
  localparam int DEPTH_BITS = (SUM_BITS > PB_BITS) ? SUM_BITS : PB_BITS;

  localparam logic [INDEX_BITS-1:0] INDEX_MAX   = {INDEX_BITS{1'b1}};
  localparam logic [END_BITS:0]     END_MIN     = (END_BITS+1)'(3);
  localparam logic [END_BITS:0]     END_MAX     = (END_BITS+1)'(MAX_BUCKETS);
  localparam logic [END_BITS-1:0]   END_RESET   = END_BITS'(512);
  localparam logic [LIMIT_BITS-1:0] LIMIT_RESET = LIMIT_BITS'(50);

  // configuration register indexes
  localparam logic [CFG_INDEX_BITS-1:0] CFG_END_BUCKET  = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_NOISE_LIMIT = 2'd1;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_PEAK_LIMIT  = 2'd2;

  typedef struct packed {
    logic accept;
    logic mul;
    logic sub;
    logic cmp;
    logic load;
  } dcd_cmd_t;

  typedef struct packed {
    logic last_bucket;
  } dcd_status_t;

endpackage

`default_nettype wire

FILE: hdl/dead_channel_detector_top.sv
// ---------------------------------------------------------------------------
// dead_channel_detector_top
// flags a readout channel that is quiet and shows no pulse over its buckets
// ---------------------------------------------------------------------------
// One ADC sample enters per item. An item with in_first_bucket high opens a
// channel and is not counted; buckets 1 up to end_bucket-1 are summed, squared
// and scanned for their minimum (the pulse is negative going). Ordinary
// buckets are taken without a stall. The last examined bucket is accumulated,
// then passes through the staged test (products, then the differences and
// the noise bound, then the two compares) before its flag is handed to the
// output register, which waits while out_stall holds the previous flag; the
// input stalls meanwhile. The flag is set when n*sumsq - sum^2 is below
// noise_limit^2*n*(n-1) and sum - n*min is below peak_limit*n, with
// n = end_bucket-1 after clamping end_bucket to 3..512. Samples past the last
// bucket are dropped without a result until the next channel start.
// Configuration writes are taken in any cycle and should arrive while no
// channel is being judged.
// ---------------------------------------------------------------------------
`default_nettype none

module dead_channel_detector_top
  import dcd_pkg::*;
(
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  // sample item channel
  input  wire logic                      in_valid,
  output logic                           in_stall,
  input  wire logic [SAMPLE_BITS-1:0]    in_adc_sample,
  input  wire logic                      in_first_bucket,
  // result item channel
  output logic                           out_valid,
  input  wire logic                      out_stall,
  output logic                           out_dead_channel,
  // configuration write port
  input  wire logic                      cfg_wr_en,
  input  wire logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  wire logic [CFG_DATA_BITS-1:0]  cfg_data
);

  // commands from the sequencer, bucket status back from the datapath
  dcd_cmd_t    cmd;
  dcd_status_t status;

  // sequencer: accept window, test stages, output valid
  dcd_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd)
  );

  // accumulators, settings and the staged arithmetic
  dcd_datapath u_datapath (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .status           (status),
    .in_adc_sample    (in_adc_sample),
    .in_first_bucket  (in_first_bucket),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .out_dead_channel (out_dead_channel)
  );

endmodule

`default_nettype wire

FILE: hdl/dcd_datapath.sv
// ---------------------------------------------------------------------------
// dcd_datapath
// accumulators, configuration registers and the staged dead-channel test
// ---------------------------------------------------------------------------
`default_nettype none

module dcd_datapath
  import dcd_pkg::*;
(
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire dcd_cmd_t                  cmd,
  output dcd_status_t                    status,
  input  wire logic [SAMPLE_BITS-1:0]    in_adc_sample,
  input  wire logic                      in_first_bucket,
  input  wire logic                      cfg_wr_en,
  input  wire logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  wire logic [CFG_DATA_BITS-1:0]  cfg_data,
  output logic                           out_dead_channel
);

  logic [END_BITS-1:0]    end_bucket_r;
  logic [LIMIT_BITS-1:0]  noise_limit_r;
  logic [LIMIT_BITS-1:0]  peak_limit_r;

  logic [INDEX_BITS-1:0]  idx_r;
  logic [SUM_BITS-1:0]    sum_r;
  logic [SQ_BITS-1:0]     sq_r;
  logic [SAMPLE_BITS-1:0] min_r;

  logic [END_BITS:0]      end_eff;
  logic [N_BITS-1:0]      last_n;
  logic [INDEX_BITS-1:0]  idx_nxt;
  logic                   in_range;

  // judge stage registers
  logic [PROD_BITS-1:0]   nsq_r;
  logic [PROD_BITS-1:0]   sum2_r;
  logic [NL2_BITS-1:0]    nl2_r;
  logic [NN_BITS-1:0]     nn_r;
  logic [SUM_BITS-1:0]    nmin_r;
  logic [PB_BITS-1:0]     pb_r;
  logic [PROD_BITS:0]     spread_r;
  logic [QB_BITS-1:0]     qb_r;
  logic [DEPTH_BITS:0]    depth_r;
  logic                   flag_r;
  logic                   dead_r;

  logic                   quiet;
  logic                   flat;

  // clamp end bucket into its working range
  always_comb begin
    if (({1'b0, end_bucket_r}) < END_MIN) begin
      end_eff = END_MIN;
    end else if (({1'b0, end_bucket_r}) > END_MAX) begin
      end_eff = END_MAX;
    end else begin
      end_eff = {1'b0, end_bucket_r};
    end
  end

  assign last_n   = N_BITS'(end_eff - (END_BITS+1)'(1));
  assign idx_nxt  = (idx_r < INDEX_MAX) ? idx_r + INDEX_BITS'(1) : idx_r;
  assign in_range = idx_nxt <= INDEX_BITS'(last_n);
  assign status.last_bucket = !in_first_bucket && (idx_nxt == INDEX_BITS'(last_n));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      end_bucket_r  <= END_RESET;
      noise_limit_r <= LIMIT_RESET;
      peak_limit_r  <= LIMIT_RESET;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_END_BUCKET:  end_bucket_r  <= END_BITS'(cfg_data);
        CFG_NOISE_LIMIT: noise_limit_r <= LIMIT_BITS'(cfg_data);
        CFG_PEAK_LIMIT:  peak_limit_r  <= LIMIT_BITS'(cfg_data);
        default: ;
      endcase
    end
  end

  // per-channel accumulation
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= '0;
      sum_r <= '0;
      sq_r  <= '0;
      min_r <= {SAMPLE_BITS{1'b1}};
    end else if (cmd.accept) begin
      if (in_first_bucket) begin
        idx_r <= '0;
        sum_r <= '0;
        sq_r  <= '0;
        min_r <= {SAMPLE_BITS{1'b1}};
      end else begin
        idx_r <= idx_nxt;
        if (in_range) begin
          sum_r <= sum_r + SUM_BITS'(in_adc_sample);
          sq_r  <= sq_r + SQ_BITS'(in_adc_sample) * SQ_BITS'(in_adc_sample);
          if (in_adc_sample < min_r) begin
            min_r <= in_adc_sample;
          end
        end
      end
    end
  end

  // differences go negative only if the end bucket moved mid channel
  assign quiet = !spread_r[PROD_BITS] &&
                 (WIDE_BITS'(spread_r[PROD_BITS-1:0]) < WIDE_BITS'(qb_r));
  assign flat  = !depth_r[DEPTH_BITS] &&
                 (DEPTH_BITS'(depth_r[DEPTH_BITS-1:0]) < DEPTH_BITS'(pb_r));

  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      nsq_r  <= PROD_BITS'(last_n) * PROD_BITS'(sq_r);
      sum2_r <= PROD_BITS'(sum_r) * PROD_BITS'(sum_r);
      nl2_r  <= NL2_BITS'(noise_limit_r) * NL2_BITS'(noise_limit_r);
      nn_r   <= NN_BITS'(last_n) * NN_BITS'(last_n - N_BITS'(1));
      nmin_r <= SUM_BITS'(last_n) * SUM_BITS'(min_r);
      pb_r   <= PB_BITS'(peak_limit_r) * PB_BITS'(last_n);
    end
    if (cmd.sub) begin
      spread_r <= {1'b0, nsq_r} - {1'b0, sum2_r};
      qb_r     <= QB_BITS'(nl2_r) * QB_BITS'(nn_r);
      depth_r  <= (DEPTH_BITS+1)'(sum_r) - (DEPTH_BITS+1)'(nmin_r);
    end
    if (cmd.cmp) begin
      flag_r <= quiet && flat;
    end
    if (cmd.load) begin
      dead_r <= flag_r;
    end
  end

  assign out_dead_channel = dead_r;

endmodule

`default_nettype wire

FILE: hdl/dcd_ctrl.sv
// ---------------------------------------------------------------------------
// dcd_ctrl
// sequences sample accumulation, the end-of-channel test and result handoff
// ---------------------------------------------------------------------------
`default_nettype none

module dcd_ctrl
  import dcd_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  output logic             out_valid,
  input  wire logic        out_stall,
  input  wire dcd_status_t status,
  output dcd_cmd_t         cmd
);

  typedef enum logic [2:0] {
    ST_ACC,
    ST_MUL,
    ST_SUB,
    ST_CMP,
    ST_LOAD
  } state_t;

  state_t state_r;
  logic   out_valid_r;
  logic   slot_free;

  assign slot_free = !out_valid_r || !out_stall;

  assign in_stall   = (state_r != ST_ACC);
  assign cmd.accept = (state_r == ST_ACC) && in_valid;
  assign cmd.mul    = (state_r == ST_MUL);
  assign cmd.sub    = (state_r == ST_SUB);
  assign cmd.cmp    = (state_r == ST_CMP);
  assign cmd.load   = (state_r == ST_LOAD) && slot_free;
  assign out_valid  = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_ACC;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= (out_valid_r && out_stall) || cmd.load;
      unique case (state_r)
        ST_ACC: begin
          if (in_valid && status.last_bucket) begin
            state_r <= ST_MUL;
          end
        end
        ST_MUL:  state_r <= ST_SUB;
        ST_SUB:  state_r <= ST_CMP;
        ST_CMP:  state_r <= ST_LOAD;
        ST_LOAD: begin
          if (slot_free) begin
            state_r <= ST_ACC;
          end
        end
        default: state_r <= ST_ACC;
      endcase
    end
  end

endmodule

`default_nettype wire

FILE: hdl/dcd_checker.sv
// ---------------------------------------------------------------------------
// dcd_checker
// port-level checks of the dead channel detector
// ---------------------------------------------------------------------------
`default_nettype none

`include "dead_channel_detector_top_defines.svh"

module dcd_checker (
  input wire logic clk,
  input wire logic rst_n,
  input wire logic in_valid,
  input wire logic in_stall,
  input wire logic in_first_bucket,
  input wire logic out_valid,
  input wire logic out_stall,
  input wire logic out_dead_channel
);

  // a held result keeps its flag
  `DCD_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_dead_channel), "stalled result changed")

  // a channel start never triggers the test
  `DCD_ASSERT_NEXT(a_first_no_stall, in_valid && !in_stall && in_first_bucket, !in_stall, "stall after channel start")

  // a busy period only begins after a sample was taken
  `DCD_ASSERT_NOW(a_stall_cause, $rose(in_stall), $past(in_valid && !in_stall), "stall without accepted item")

  // a new result comes only out of the test sequence
  `DCD_ASSERT_NOW(a_result_cause, $rose(out_valid), $past(in_stall), "result outside test sequence")

endmodule

bind dead_channel_detector_top dcd_checker u_dcd_checker (.*);

`default_nettype wire

FILE: test/dead_channel_detector_top_test.sv
// ----------------------------------------------------------------------------
// dead_channel_detector_top_test
// self-checking bench for the dead channel detector
// ----------------------------------------------------------------------------
// Sample items are fed from a queue through a valid/stall driver. A monitor
// keeps its own copy of the channel accumulators: it works out the dead flag
// that each last bucket should produce, and it checks the result items
// against those flags in order. The run starts with the reset settings and
// with samples that come before any channel start; near the end of that
// full-length channel the end bucket is raised past its maximum. A short
// directed part follows, then random phases with short channels. Both sides
// idle at random, except before the end bucket write and in one random phase.
// ----------------------------------------------------------------------------

module dead_channel_detector_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  import dcd_pkg::*;

  typedef struct {
    logic [SAMPLE_BITS-1:0] adc;
    logic                   first;
  } bucket_item_t;

  logic                      clk;
  logic                      rst_n           = 1'b0;
  logic                      in_valid        = 1'b0;
  logic                      in_stall;
  logic [SAMPLE_BITS-1:0]    in_adc_sample   = '0;
  logic                      in_first_bucket = 1'b0;
  logic                      out_valid;
  logic                      out_stall       = 1'b0;
  logic                      out_dead_channel;
  logic                      cfg_wr_en       = 1'b0;
  logic [CFG_INDEX_BITS-1:0] cfg_index       = CFG_END_BUCKET;
  logic [CFG_DATA_BITS-1:0]  cfg_data        = '0;

  dead_channel_detector_top DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_adc_sample    (in_adc_sample),
    .in_first_bucket  (in_first_bucket),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_dead_channel (out_dead_channel),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  // items waiting for the driver, dead flags waiting for the result channel
  bucket_item_t sample_queue[$];
  logic         dead_flag_queue[$];

  // percent of cycles in which each side holds back
  int idle_pct = 6;
  logic item_taken = 1'b0;

  int mismatch_count = 0;
  int items_accepted = 0;
  int dead_seen = 0;
  int live_seen = 0;
  int config_writes = 0;

  // bench copy of the registers and of the channel accumulators
  logic [END_BITS-1:0]    model_end   = END_RESET;
  logic [LIMIT_BITS-1:0]  model_noise = LIMIT_RESET;
  logic [LIMIT_BITS-1:0]  model_peak  = LIMIT_RESET;
  logic [INDEX_BITS-1:0]  chan_index  = '0;
  logic [SUM_BITS-1:0]    chan_sum    = '0;
  logic [SQ_BITS-1:0]     chan_square = '0;
  logic [SAMPLE_BITS-1:0] chan_lowest = '1;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // channel model
  // ---------------------------------------------------------------------------

  function automatic void restart_channel();
    chan_index  = '0;
    chan_sum    = '0;
    chan_square = '0;
    chan_lowest = '1;
  endfunction

  // end bucket register clamped to the range the block honors
  function automatic int clamp_end(logic [END_BITS-1:0] e);
    int v;
    v = e;
    if (v < 3) v = 3;
    if (v > MAX_BUCKETS) v = MAX_BUCKETS;
    return v;
  endfunction

  // exact integer form of "std dev below noise limit and mean-min below peak limit"
  function automatic logic judge_dead(int n);
    longint unsigned nn, spread, quiet_bound, depth, peak_bound;
    nn          = n;
    spread      = nn * chan_square - chan_sum * chan_sum;
    quiet_bound = model_noise * model_noise * nn * (nn - 1);
    depth       = chan_sum - nn * chan_lowest;
    peak_bound  = model_peak * nn;
    return (spread < quiet_bound) && (depth < peak_bound);
  endfunction

  task automatic track_bucket(logic [SAMPLE_BITS-1:0] adc, logic first);
    int last;
    if (first) begin
      restart_channel();
      return;
    end
    if (chan_index != INDEX_MAX) chan_index++;
    last = clamp_end(model_end) - 1;
    // past the last bucket: dropped until the next channel start
    if (chan_index > last) return;
    chan_sum    = chan_sum + adc;
    chan_square = chan_square + adc * adc;
    if (adc < chan_lowest) chan_lowest = adc;
    if (chan_index == last) dead_flag_queue = {dead_flag_queue, judge_dead(last)};
  endtask

  // ---------------------------------------------------------------------------
  // driver: a new item goes out only once the previous one was taken
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    bucket_item_t nxt;
    out_stall <= rst_n && ($urandom_range(99) < idle_pct);
    if (!in_valid || item_taken) begin
      if (rst_n && sample_queue.size() != 0 && $urandom_range(99) >= idle_pct) begin
        nxt = sample_queue.pop_front();
        in_valid        <= 1'b1;
        in_adc_sample   <= nxt.adc;
        in_first_bucket <= nxt.first;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // monitor: check result items first, then feed the accepted sample to the model
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    logic expected;
    item_taken <= rst_n && in_valid && !in_stall;
    if (!rst_n) begin
      restart_channel();
    end else begin
      if (out_valid && !out_stall) begin
        if (dead_flag_queue.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 20)
            $display("%0t ns unexpected result item: expected none actual dead=%0b",
                     $time, out_dead_channel);
        end else begin
          expected = dead_flag_queue.pop_front();
          if (out_dead_channel !== expected) begin
            mismatch_count++;
            if (mismatch_count <= 20)
              $display("%0t ns dead flag mismatch: expected %0b actual %0b",
                       $time, expected, out_dead_channel);
          end
          if (expected) dead_seen++;
          else live_seen++;
        end
      end
      if (in_valid && !in_stall) begin
        track_bucket(in_adc_sample, in_first_bucket);
        items_accepted++;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------

  // registers change only while nothing is in flight, so the model updates here
  task automatic write_register(logic [CFG_INDEX_BITS-1:0] idx,
                                logic [CFG_DATA_BITS-1:0] data);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    case (idx)
      CFG_END_BUCKET:  model_end   = data[END_BITS-1:0];
      CFG_NOISE_LIMIT: model_noise = data[LIMIT_BITS-1:0];
      CFG_PEAK_LIMIT:  model_peak  = data[LIMIT_BITS-1:0];
      default: ;
    endcase
    config_writes++;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // sender pauses until every flag has come, then the pipe is given time to drain
  task automatic settle();
    while (sample_queue.size() != 0 || in_valid || dead_flag_queue.size() != 0)
      @(posedge clk);
    repeat (16) @(posedge clk);
  endtask

  task automatic push_item(logic [SAMPLE_BITS-1:0] adc, logic first);
    bucket_item_t it;
    it.adc   = adc;
    it.first = first;
    sample_queue = {sample_queue, it};
  endtask

  // optional channel start, then samples around a pedestal; amp 4095 means
  // fully random values, a pulse pulls one sample down
  task automatic add_channel(int samples, int level, int amp, bit pulse, bit with_start);
    int v;
    int dip_at;
    dip_at = (pulse && samples > 0) ? int'($urandom_range(samples - 1, 0)) : -1;
    if (with_start) push_item(SAMPLE_BITS'($urandom), 1'b1);
    for (int k = 0; k < samples; k++) begin
      if (amp >= 4095) v = int'($urandom_range(4095));
      else v = level - amp + int'($urandom_range(2 * amp));
      if (k == dip_at) v = v - int'($urandom_range(4095, 1));
      if (v < 0) v = 0;
      if (v > 4095) v = 4095;
      push_item(SAMPLE_BITS'(v), 1'b0);
    end
  endtask

  function automatic logic [CFG_DATA_BITS-1:0] pick_limit();
    case ($urandom_range(7))
      0: return '0;
      1: return 12'd4095;
      2: return CFG_DATA_BITS'($urandom_range(4095));
      default: return CFG_DATA_BITS'($urandom_range(64, 1));
    endcase
  endfunction

  function automatic int pick_spread();
    case ($urandom_range(7))
      0: return 0;
      1, 2, 3: return $urandom_range(4, 1);
      4, 5: return $urandom_range(60, 5);
      6: return $urandom_range(400, 61);
      default: return 4095;
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------
  initial begin
    int phase;
    int random_items;
    int phase_items;
    int last;
    int e;
    int n;

    repeat (8) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;

    // reset settings with no idling, samples before any channel start count
    // as buckets 1, 2, ...; then the end bucket goes above the maximum and
    // acts as the maximum, so the flag comes at bucket 511
    idle_pct = 0;
    add_channel(505, 1500, 2, 0, 0);
    settle();
    idle_pct = 6;
    write_register(CFG_END_BUCKET, 12'd1023);
    add_channel(6, 1500, 2, 0, 0);
    add_channel(3, 0, 4095, 0, 0);    // past the end, dropped
    settle();

    // shortest channel, widest limits, sample extremes
    write_register(CFG_END_BUCKET, 12'd3);
    write_register(CFG_NOISE_LIMIT, 12'd4095);
    write_register(CFG_PEAK_LIMIT, 12'd4095);
    push_item(12'd4095, 1'b1); push_item(12'd0, 1'b0);    push_item(12'd0, 1'b0);
    push_item(12'd0, 1'b1);    push_item(12'd4095, 1'b0); push_item(12'd4095, 1'b0);
    push_item(12'hA5A, 1'b1);  push_item(12'd0, 1'b0);    push_item(12'd4095, 1'b0);
    settle();

    // zero limits never pass their strict test
    write_register(CFG_NOISE_LIMIT, 12'd0);
    add_channel(2, 100, 0, 0, 1);
    settle();
    write_register(CFG_NOISE_LIMIT, 12'd4095);
    write_register(CFG_PEAK_LIMIT, 12'd0);
    add_channel(2, 7, 0, 0, 1);
    settle();
    write_register(CFG_PEAK_LIMIT, 12'd4095);

    // end bucket lowered below where the open channel already is: no flag
    write_register(CFG_END_BUCKET, 12'd10);
    add_channel(6, 2000, 3, 0, 1);
    settle();
    write_register(CFG_END_BUCKET, 12'd5);
    add_channel(2, 2000, 3, 0, 0);
    // end bucket raised while a channel is open: flag at the new last bucket
    add_channel(2, 800, 1, 0, 1);
    settle();
    write_register(CFG_END_BUCKET, 12'd8);
    add_channel(5, 800, 1, 1, 0);
    settle();

    // upper data bits are not part of the register; samples past the end
    // stay silent until the next channel start
    write_register(CFG_END_BUCKET, 12'hC02);
    add_channel(2, 300, 0, 0, 1);
    add_channel(12, 0, 4095, 0, 0);
    add_channel(2, 300, 0, 0, 1);
    settle();

    // random phases of short channels, one phase with no idling at all
    phase = 0;
    random_items = 0;
    while (random_items < 240) begin
      case (phase % 5)
        0: e = $urandom_range(2, 0);
        1: e = $urandom_range(8, 3);
        2: e = $urandom_range(40, 9);
        default: e = $urandom_range(16, 3);
      endcase
      write_register(CFG_END_BUCKET, {2'($urandom), 10'(e)});
      write_register(CFG_NOISE_LIMIT, pick_limit());
      write_register(CFG_PEAK_LIMIT, pick_limit());
      last = clamp_end(10'(e)) - 1;
      idle_pct = (phase == 2) ? 0 : 6;
      phase_items = 0;
      while (phase_items < 60) begin
        case ($urandom_range(19))
          0: begin
            // channel cut short by the next start
            n = $urandom_range(last - 1, 0);
            add_channel(n, $urandom_range(4095), pick_spread(), 0, 1);
            phase_items += n + 1;
          end
          1: begin
            // full channel followed by dropped samples
            add_channel(last, $urandom_range(4095), pick_spread(), $urandom_range(1), 1);
            add_channel($urandom_range(5, 1), 0, 4095, 0, 0);
            phase_items += last + 1;
          end
          2: begin
            // stray channel starts
            n = $urandom_range(3, 1);
            for (int k = 0; k < n; k++) push_item(SAMPLE_BITS'($urandom), 1'b1);
            phase_items += n;
          end
          default: begin
            add_channel(last, $urandom_range(4095), pick_spread(),
                        $urandom_range(9) < 3, 1);
            phase_items += last + 1;
          end
        endcase
      end
      settle();
      random_items += phase_items;
      phase++;
    end

    $display("covered %0d sample items, %0d channels judged (%0d dead, %0d live)",
             items_accepted, dead_seen + live_seen, dead_seen, live_seen);
    $display("%0d register writes, end bucket from below 3 to above 512, limits 0 to 4095",
             config_writes);
    if (mismatch_count == 0 && dead_flag_queue.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // hang guard, far beyond the slowest legal run
  initial begin
    #400_000;
    $display("TB_ERROR");
    $finish;
  end

endmodule
